### rtl/core/ome_pkg.sv
package ome_pkg;

    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_WORD    = 2'd2;

    localparam logic [1:0] ARG_NONE   = 2'd0;
    localparam logic [1:0] ARG_INT    = 2'd1;
    localparam logic [1:0] ARG_FLOAT  = 2'd2;
    localparam logic [1:0] ARG_STRING = 2'd3;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [7:0] TAG_COMMA = 8'h2C;
    localparam logic [7:0] TAG_INT   = 8'h69;
    localparam logic [7:0] TAG_FLOAT = 8'h66;
    localparam logic [7:0] TAG_STR   = 8'h73;

    typedef struct packed {
        logic        open_end;
        logic        slip;
        logic        is_word;
        logic [31:0] data;
        logic [2:0]  pad_cnt;
        logic        has_tag;
        logic [1:0]  tag_type;
        logic        finish;
        logic        close_end;
    } job_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] kind, input logic [1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos == 2'd0) begin
            b = TAG_COMMA;
        end else if (pos == 2'd1) begin
            case (kind)
                ARG_INT:    b = TAG_INT;
                ARG_FLOAT:  b = TAG_FLOAT;
                ARG_STRING: b = TAG_STR;
                default:    b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

### rtl/core/osc_message_slip_encoder.sv
// an accepted word is written into the job queue, and the back sequencer then registers each of its output bytes
// throughput: one input word per cycle while the job queue has room
// each word is expanded to 1 to 11 output bytes, one byte per cycle from the back sequencer while m_tready is high
// the back sequencer's byte rate sets the sustained word rate
// reset: synchronous active-low aresetn clears slip framing, message state, queue and output
module osc_message_slip_encoder
    import ome_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, arg_word
    input  logic [3:0]  s_tuser,   // mode, arg_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [0:0]  m_tuser,   // last_of_run
    output logic        m_tlast
);

    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic head_valid;
    job_t head_job;

    ome_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    ome_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    ome_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/core/ome_front.sv
module ome_front
    import ome_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    localparam logic [1:0] PH_PATTERN = 2'd0;
    localparam logic [1:0] PH_STRING  = 2'd1;
    localparam logic [1:0] PH_WORD    = 2'd2;

    logic       slip_reg;
    logic [1:0] phase_reg, phase_next;
    logic       started_reg, started_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [1:0]  mode;
    logic [1:0]  arg_type;
    logic [7:0]  data_byte;
    logic [31:0] arg_word;
    logic        accept;
    logic        in_seq;
    logic [1:0]  cnt_inc;
    logic [2:0]  pad;

    assign mode      = s_tuser[1:0];
    assign arg_type  = s_tuser[3:2];
    assign data_byte = s_tdata[7:0];
    assign arg_word  = s_tdata[39:8];
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;
    assign cnt_inc   = cnt_reg + 2'd1;
    assign pad       = 3'd4 - {1'b0, cnt_inc};

    always_comb begin
        in_seq             = 1'b0;
        phase_next         = phase_reg;
        started_next       = started_reg;
        cnt_next           = cnt_reg;
        push_job.open_end  = 1'b0;
        push_job.slip      = slip_reg;
        push_job.is_word   = 1'b0;
        push_job.data      = {24'd0, data_byte};
        push_job.pad_cnt   = 3'd0;
        push_job.has_tag   = 1'b0;
        push_job.tag_type  = arg_type;
        push_job.finish    = 1'b0;
        push_job.close_end = 1'b0;
        unique case (phase_reg)
            PH_PATTERN: begin
                if (mode == MODE_PATTERN) begin
                    in_seq            = 1'b1;
                    push_job.open_end = !started_reg && slip_reg;
                    started_next      = 1'b1;
                    cnt_next          = cnt_inc;
                    if (s_tlast) begin
                        push_job.pad_cnt = pad;
                        push_job.has_tag = 1'b1;
                        cnt_next         = 2'd0;
                        if (arg_type == ARG_NONE) begin
                            push_job.finish = 1'b1;
                            started_next    = 1'b0;
                        end else if (arg_type == ARG_STRING) begin
                            phase_next = PH_STRING;
                        end else begin
                            phase_next = PH_WORD;
                        end
                    end
                end
            end
            PH_STRING: begin
                if (mode == MODE_STRING) begin
                    in_seq   = 1'b1;
                    cnt_next = cnt_inc;
                    if (s_tlast) begin
                        push_job.pad_cnt = pad;
                        push_job.finish  = 1'b1;
                        cnt_next         = 2'd0;
                        started_next     = 1'b0;
                        phase_next       = PH_PATTERN;
                    end
                end
            end
            PH_WORD: begin
                if (mode == MODE_WORD) begin
                    in_seq           = 1'b1;
                    push_job.is_word = 1'b1;
                    push_job.data    = arg_word;
                    push_job.finish  = 1'b1;
                    cnt_next         = 2'd0;
                    started_next     = 1'b0;
                    phase_next       = PH_PATTERN;
                end
            end
            default: begin
                in_seq = 1'b0;
            end
        endcase
        push_job.close_end = push_job.finish && slip_reg;
    end

    assign push = accept && in_seq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slip_reg    <= 1'b0;
            phase_reg   <= PH_PATTERN;
            started_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                slip_reg <= cfg_wr_data;
            end
            if (push) begin
                phase_reg   <= phase_next;
                started_reg <= started_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("message phase left its legal range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_PATTERN |-> started_reg)
        else $error("argument phase without a message in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> s_tvalid && s_tready)
        else $error("job pushed without an accepted word");

endmodule

### rtl/core/ome_queue.sv
module ome_queue
    import ome_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

### rtl/core/ome_back.sv
module ome_back
    import ome_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    input  job_t       job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [0:0] m_tuser,
    output logic       m_tlast
);

    localparam logic [2:0] SEG_OPEN  = 3'd0;
    localparam logic [2:0] SEG_DATA  = 3'd1;
    localparam logic [2:0] SEG_PAD   = 3'd2;
    localparam logic [2:0] SEG_TAG   = 3'd3;
    localparam logic [2:0] SEG_CLOSE = 3'd4;
    localparam logic [2:0] SEG_DONE  = 3'd5;

    logic       busy_reg;
    logic [2:0] seg_reg;
    logic [1:0] idx_reg;
    logic       esc_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_run_reg;
    logic       out_end_reg;

    logic [2:0] cur_seg;
    logic [1:0] cur_idx;
    logic [7:0] raw;
    logic [7:0] word_byte;
    logic       special;
    logic [7:0] out_byte;
    logic       step_done;
    logic [2:0] after_data;
    logic [2:0] after_pad;
    logic [2:0] after_tag;
    logic [2:0] nseg;
    logic [1:0] nidx;
    logic       job_last;
    logic       load;

    assign cur_seg = busy_reg ? seg_reg : (job.open_end ? SEG_OPEN : SEG_DATA);
    assign cur_idx = busy_reg ? idx_reg : 2'd0;

    always_comb begin
        case (cur_idx)
            2'd0:    word_byte = job.is_word ? job.data[31:24] : job.data[7:0];
            2'd1:    word_byte = job.data[23:16];
            2'd2:    word_byte = job.data[15:8];
            default: word_byte = job.data[7:0];
        endcase
    end

    assign after_tag  = job.close_end ? SEG_CLOSE : SEG_DONE;
    assign after_pad  = job.has_tag ? SEG_TAG : after_tag;
    assign after_data = (job.pad_cnt != 3'd0) ? SEG_PAD : after_pad;

    always_comb begin
        raw  = 8'h00;
        nseg = SEG_DONE;
        nidx = 2'd0;
        unique case (cur_seg)
            SEG_OPEN: begin
                raw  = SLIP_END;
                nseg = SEG_DATA;
            end
            SEG_DATA: begin
                raw = word_byte;
                if (job.is_word && cur_idx != 2'd3) begin
                    nseg = SEG_DATA;
                    nidx = cur_idx + 2'd1;
                end else begin
                    nseg = after_data;
                end
            end
            SEG_PAD: begin
                raw = 8'h00;
                if (({1'b0, cur_idx} + 3'd1) != job.pad_cnt) begin
                    nseg = SEG_PAD;
                    nidx = cur_idx + 2'd1;
                end else begin
                    nseg = after_pad;
                end
            end
            SEG_TAG: begin
                raw = tag_byte(job.tag_type, cur_idx);
                if (cur_idx != 2'd3) begin
                    nseg = SEG_TAG;
                    nidx = cur_idx + 2'd1;
                end else begin
                    nseg = after_tag;
                end
            end
            SEG_CLOSE: begin
                raw  = SLIP_END;
                nseg = SEG_DONE;
            end
            default: begin
                raw  = 8'h00;
                nseg = SEG_DONE;
            end
        endcase
    end

    assign special = job.slip && (cur_seg == SEG_DATA) && ((raw == SLIP_END) || (raw == SLIP_ESC));

    always_comb begin
        if (special && !esc_reg) begin
            out_byte  = SLIP_ESC;
            step_done = 1'b0;
        end else if (special) begin
            out_byte  = (raw == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
            step_done = 1'b1;
        end else begin
            out_byte  = raw;
            step_done = 1'b1;
        end
    end

    assign job_last = step_done && (nseg == SEG_DONE);
    assign load     = job_valid && (!out_valid_reg || m_tready);
    assign pop      = load && job_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            seg_reg       <= SEG_OPEN;
            idx_reg       <= 2'd0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            if (!step_done) begin
                busy_reg <= 1'b1;
                seg_reg  <= cur_seg;
                idx_reg  <= cur_idx;
                esc_reg  <= 1'b1;
            end else begin
                esc_reg  <= 1'b0;
                busy_reg <= !job_last;
                seg_reg  <= nseg;
                idx_reg  <= nidx;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= out_byte;
            out_run_reg  <= job_last;
            out_end_reg  <= job_last && job.finish;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_run_reg;
    assign m_tlast    = out_end_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> busy_reg && seg_reg == SEG_DATA)
        else $error("escape pending outside a data byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> job_valid && load)
        else $error("job retired without a loaded byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> job_valid)
        else $error("job in progress left the queue head");

endmodule
